### rtl/core/afs_pkg.sv
// ----------------------------------------------------------------------------
// afs_pkg
// Shared types and constants of the animation frame sequencer.
// ----------------------------------------------------------------------------
package afs_pkg;

  localparam int FRAME_W = 8;
  localparam int SLOT_W  = 3;
  localparam int EVA_W   = FRAME_W + SLOT_W;

  localparam logic [8:0]  MAX_FRAMES    = 9'd256;
  localparam logic [3:0]  MAX_EVENTS    = 4'd8;
  localparam logic [15:0] RESET_STEP_MS = 16'd75;

  localparam logic [2:0] FUNC_TICK   = 3'd0;
  localparam logic [2:0] FUNC_PLAY   = 3'd1;
  localparam logic [2:0] FUNC_STOP   = 3'd2;
  localparam logic [2:0] FUNC_WFRAME = 3'd3;
  localparam logic [2:0] FUNC_WEVENT = 3'd4;

  localparam logic [1:0] KIND_STATUS  = 2'd0;
  localparam logic [1:0] KIND_EVENT   = 2'd1;
  localparam logic [1:0] KIND_DESTROY = 2'd2;

  localparam logic [1:0] MODE_LOOP     = 2'd0;
  localparam logic [1:0] MODE_ONCE     = 2'd1;
  localparam logic [1:0] MODE_DESTROY  = 2'd2;
  localparam logic [1:0] MODE_PINGPONG = 2'd3;

  localparam logic [1:0] CFG_STEP  = 2'd0;
  localparam logic [1:0] CFG_MODE  = 2'd1;
  localparam logic [1:0] CFG_COUNT = 2'd2;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] delta_ms;
    logic [7:0]  frame_index;
    logic [2:0]  event_slot;
    logic [15:0] frame_dur;
    logic [3:0]  event_count;
    logic [7:0]  event_code;
  } afs_in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] event_value;
    logic [7:0] frame_now;
    logic       is_playing;
    logic       is_finished;
    logic       last;
  } afs_out_t;

  typedef struct packed {
    logic capture;
    logic do_cmd;
    logic acc_add;
    logic step;
    logic ft_rd;
    logic ev_start;
    logic ev_emit;
    logic out_destroy;
    logic out_status;
  } afs_cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       tick_live;
    logic       changed;
    logic       destroy;
    logic       ev_none;
    logic       ev_last;
    logic       out_free;
  } afs_sts_t;

endpackage

### rtl/core/animation_frame_sequencer_top.sv
// ----------------------------------------------------------------------------
// animation_frame_sequencer_top
// Steps one animation through its frames and reports frame events and status.
//
// Input words carry a function: tick, play, stop, frame table write or event
// slot write. Each input word yields zero or more event words or a destroy
// word, followed by one status word with last set. Output words leave
// through a result register, so a new input word is taken while the final
// status word still waits for the receiver. Configuration writes are always
// accepted and are applied on the edge of the handshake; write them only
// while the block is idle.
// A non-tick word, or a tick while the sequence is idle, goes from dispatch
// straight to its status word. A live tick adds its delta, steps the frame
// and reads the frame table again; on a new frame it emits the stored
// events of that frame, and a destroy ending emits a destroy word. The
// registered table reads feed one result register that emits one word per
// cycle while the receiver keeps up. The block works on one input word at
// a time. Reset clears the sequencer state, configuration and the frame
// table; the event slots are undefined until written. A stalled receiver
// holds the block in place until the pending word is taken.
// ----------------------------------------------------------------------------
module animation_frame_sequencer_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  afs_pkg::afs_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output afs_pkg::afs_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

  afs_pkg::afs_cmd_t cmd;
  afs_pkg::afs_sts_t sts;

  assign cfg_ready = 1'b1;

  afs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  afs_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Only the status word may still be pending when a new word can enter.
  a_idle_pending_is_status: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && out_valid |-> out_data.last)
    else $error("pending word at input acceptance is not a status word");

  // A destroy word is always followed directly by the status word.
  a_destroy_then_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.kind == afs_pkg::KIND_DESTROY |=>
      out_valid && out_data.kind == afs_pkg::KIND_STATUS && out_data.last)
    else $error("destroy word not followed by status word");

  // Only event words carry an event value.
  a_value_only_on_events: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind != afs_pkg::KIND_EVENT |-> out_data.event_value == 8'd0)
    else $error("nonzero event value on a non-event word");

  // No input is taken while the sequencer works on an earlier word.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");

endmodule

### rtl/core/afs_ctrl.sv
// ----------------------------------------------------------------------------
// afs_ctrl
// Sequencing state machine: dispatches each word and steps the datapath.
// ----------------------------------------------------------------------------
module afs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  afs_pkg::afs_sts_t sts,
  output afs_pkg::afs_cmd_t cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DISP    = 3'd1;
  localparam logic [2:0] S_STEP    = 3'd2;
  localparam logic [2:0] S_POST    = 3'd3;
  localparam logic [2:0] S_EVSTART = 3'd4;
  localparam logic [2:0] S_EMIT    = 3'd5;
  localparam logic [2:0] S_DESTROY = 3'd6;
  localparam logic [2:0] S_STATUS  = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          cmd.ft_rd   = 1'b1;
          state_nxt   = S_DISP;
        end
      end
      S_DISP: begin
        if (sts.func == afs_pkg::FUNC_TICK && sts.tick_live) begin
          cmd.acc_add = 1'b1;
          state_nxt   = S_STEP;
        end else begin
          cmd.do_cmd = 1'b1;
          state_nxt  = S_STATUS;
        end
      end
      S_STEP: begin
        cmd.step  = 1'b1;
        state_nxt = S_POST;
      end
      S_POST: begin
        cmd.ft_rd = 1'b1;
        priority if (sts.destroy) begin
          state_nxt = S_DESTROY;
        end else if (sts.changed) begin
          state_nxt = S_EVSTART;
        end else begin
          state_nxt = S_STATUS;
        end
      end
      S_EVSTART: begin
        cmd.ev_start = 1'b1;
        state_nxt    = sts.ev_none ? S_STATUS : S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.ev_emit = 1'b1;
          if (sts.ev_last) begin
            state_nxt = S_STATUS;
          end
        end
      end
      S_DESTROY: begin
        if (sts.out_free) begin
          cmd.out_destroy = 1'b1;
          state_nxt       = S_STATUS;
        end
      end
      S_STATUS: begin
        if (sts.out_free) begin
          cmd.out_status = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/core/afs_datapath.sv
// ----------------------------------------------------------------------------
// afs_datapath
// Sequencer state, configuration, frame and event tables, and result register.
// ----------------------------------------------------------------------------
module afs_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  afs_pkg::afs_in_t  in_data,
  input  logic              cfg_valid,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output logic              out_valid,
  input  logic              out_ready,
  output afs_pkg::afs_out_t out_data,
  input  afs_pkg::afs_cmd_t cmd,
  output afs_pkg::afs_sts_t sts
);

  // Configuration.
  logic [15:0] step_ms_r;
  logic [1:0]  mode_r;
  logic [8:0]  count_r;

  // Sequencer state.
  logic [31:0] acc_r, acc_nxt;
  logic [7:0]  cur_r, cur_nxt;
  logic        playing_r, playing_nxt;
  logic        finished_r, finished_nxt;
  logic        rev_r, rev_nxt;
  logic        changed_r, changed_nxt;
  logic        destroy_r, destroy_nxt;

  afs_pkg::afs_in_t item_r;

  // Tables.
  logic [19:0] ft_mem [afs_pkg::MAX_FRAMES];
  logic [255:0] ft_valid_r;
  logic [19:0] ft_q_r;
  logic        ft_v_r;
  logic [7:0]  ev_mem [2**afs_pkg::EVA_W];
  logic [7:0]  ev_q_r;
  logic        ev_rd;
  logic [afs_pkg::SLOT_W-1:0] ev_rd_slot;
  logic [3:0]  ev_n_r;
  logic [3:0]  ev_idx_r;

  logic        out_valid_r;
  afs_pkg::afs_out_t out_data_r;

  logic [8:0]  count_eff;
  logic [15:0] ft_dur;
  logic [3:0]  ft_cnt;
  logic [15:0] dur_sel;
  logic [32:0] sum;
  logic [32:0] diff;
  logic        at_end;
  logic [3:0]  ev_n;
  logic        out_free;
  logic        out_load;

  assign count_eff = (count_r > afs_pkg::MAX_FRAMES) ? afs_pkg::MAX_FRAMES : count_r;
  assign ft_dur    = ft_q_r[19:4];
  assign ft_cnt    = ft_q_r[3:0];
  assign dur_sel   = (ft_v_r && ft_dur != 16'd0) ? ft_dur : step_ms_r;
  assign sum       = {1'b0, acc_r} + {1'b0, item_r.delta_ms};
  assign diff      = {1'b0, acc_r} - {17'd0, dur_sel};
  assign at_end    = ({1'b0, cur_r} + 9'd1) >= count_eff;
  assign ev_n      = !ft_v_r ? 4'd0 :
                     (ft_cnt > afs_pkg::MAX_EVENTS) ? afs_pkg::MAX_EVENTS : ft_cnt;
  assign out_free  = !out_valid_r || out_ready;
  assign out_load  = cmd.ev_emit || cmd.out_destroy || cmd.out_status;

  assign sts.func      = item_r.func;
  assign sts.tick_live = playing_r && !finished_r && (count_eff != 9'd0);
  assign sts.changed   = changed_r;
  assign sts.destroy   = destroy_r;
  assign sts.ev_none   = (ev_n == 4'd0);
  assign sts.ev_last   = ((ev_idx_r + 4'd1) == ev_n_r);
  assign sts.out_free  = out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_ms_r <= afs_pkg::RESET_STEP_MS;
      mode_r    <= afs_pkg::MODE_LOOP;
      count_r   <= 9'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        afs_pkg::CFG_STEP:  step_ms_r <= cfg_data;
        afs_pkg::CFG_MODE:  mode_r    <= cfg_data[1:0];
        afs_pkg::CFG_COUNT: count_r   <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
  end

  always_comb begin
    acc_nxt      = acc_r;
    cur_nxt      = cur_r;
    playing_nxt  = playing_r;
    finished_nxt = finished_r;
    rev_nxt      = rev_r;
    changed_nxt  = changed_r;
    destroy_nxt  = destroy_r;
    if (cmd.do_cmd) begin
      if (item_r.func == afs_pkg::FUNC_PLAY) begin
        acc_nxt      = 32'd0;
        cur_nxt      = 8'd0;
        playing_nxt  = 1'b1;
        finished_nxt = 1'b0;
        rev_nxt      = 1'b0;
      end else if (item_r.func == afs_pkg::FUNC_STOP) begin
        playing_nxt = 1'b0;
      end
    end
    if (cmd.acc_add) begin
      acc_nxt     = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      changed_nxt = 1'b0;
      destroy_nxt = 1'b0;
    end
    if (cmd.step && !diff[32]) begin
      acc_nxt = diff[31:0];
      unique case (mode_r)
        afs_pkg::MODE_LOOP: begin
          cur_nxt = at_end ? 8'd0 : cur_r + 8'd1;
        end
        afs_pkg::MODE_ONCE, afs_pkg::MODE_DESTROY: begin
          if (at_end) begin
            finished_nxt = 1'b1;
            playing_nxt  = 1'b0;
          end else begin
            cur_nxt = cur_r + 8'd1;
          end
        end
        default: begin
          if (!rev_r) begin
            if (at_end) begin
              rev_nxt = 1'b1;
              if (cur_r != 8'd0) begin
                cur_nxt = cur_r - 8'd1;
              end
            end else begin
              cur_nxt = cur_r + 8'd1;
            end
          end else begin
            if (cur_r == 8'd0) begin
              rev_nxt = 1'b0;
              if (count_eff > 9'd1) begin
                cur_nxt = 8'd1;
              end
            end else begin
              cur_nxt = cur_r - 8'd1;
            end
          end
        end
      endcase
      destroy_nxt = (mode_r == afs_pkg::MODE_DESTROY) && finished_nxt;
      changed_nxt = (cur_nxt != cur_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r      <= 32'd0;
      cur_r      <= 8'd0;
      playing_r  <= 1'b0;
      finished_r <= 1'b0;
      rev_r      <= 1'b0;
      changed_r  <= 1'b0;
      destroy_r  <= 1'b0;
    end else begin
      acc_r      <= acc_nxt;
      cur_r      <= cur_nxt;
      playing_r  <= playing_nxt;
      finished_r <= finished_nxt;
      rev_r      <= rev_nxt;
      changed_r  <= changed_nxt;
      destroy_r  <= destroy_nxt;
    end
  end

  // Frame table: duration and event count per frame.
  always_ff @(posedge clk) begin
    if (cmd.do_cmd && item_r.func == afs_pkg::FUNC_WFRAME) begin
      ft_mem[item_r.frame_index] <= {item_r.frame_dur, item_r.event_count};
    end
    if (cmd.ft_rd) begin
      ft_q_r <= ft_mem[cur_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ft_valid_r <= '0;
      ft_v_r     <= 1'b0;
    end else begin
      if (cmd.do_cmd && item_r.func == afs_pkg::FUNC_WFRAME) begin
        ft_valid_r[item_r.frame_index] <= 1'b1;
      end
      if (cmd.ft_rd) begin
        ft_v_r <= ft_valid_r[cur_r];
      end
    end
  end

  // Event table: one identifier per frame and slot.
  assign ev_rd      = cmd.ev_start || cmd.ev_emit;
  assign ev_rd_slot = cmd.ev_start ? '0 : ev_idx_r[afs_pkg::SLOT_W-1:0] + 3'd1;

  always_ff @(posedge clk) begin
    if (cmd.do_cmd && item_r.func == afs_pkg::FUNC_WEVENT) begin
      ev_mem[{item_r.frame_index, item_r.event_slot}] <= item_r.event_code;
    end
    if (ev_rd) begin
      ev_q_r <= ev_mem[{cur_r, ev_rd_slot}];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ev_start) begin
      ev_n_r   <= ev_n;
      ev_idx_r <= 4'd0;
    end else if (cmd.ev_emit) begin
      ev_idx_r <= ev_idx_r + 4'd1;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.frame_now   <= cur_r;
      out_data_r.is_playing  <= playing_r;
      out_data_r.is_finished <= finished_r;
      out_data_r.last        <= cmd.out_status;
      priority if (cmd.ev_emit) begin
        out_data_r.kind        <= afs_pkg::KIND_EVENT;
        out_data_r.event_value <= ev_q_r;
      end else if (cmd.out_destroy) begin
        out_data_r.kind        <= afs_pkg::KIND_DESTROY;
        out_data_r.event_value <= 8'd0;
      end else begin
        out_data_r.kind        <= afs_pkg::KIND_STATUS;
        out_data_r.event_value <= 8'd0;
      end
    end
  end

endmodule

### tb/animation_frame_sequencer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// animation_frame_sequencer_top_tb
// Self-checking bench for the animation frame sequencer.
//
// Frame table and event slot writes, play, stop and tick words are driven
// over the input channel. A predictor in the bench follows the sequencer
// state and queues the event, destroy and status words that each accepted
// word should produce. Every result word is compared field by field with
// the oldest queued word. Directed tests cover idle ticks, event bursts,
// accumulator saturation, the end modes, ping-pong and frame count limits.
// Random traffic then runs under several sender and receiver idle patterns.
// One long receiver hold-off fills the block and stalls its input.
// ----------------------------------------------------------------------------
module animation_frame_sequencer_top_tb;

  localparam int          CLK_HALF          = 5;
  localparam int          CYCLE_LIMIT       = 200000;
  localparam logic [2:0]  FUNC_UNUSED_FIRST = 3'd5;
  localparam logic [2:0]  FUNC_UNUSED_LAST  = 3'd7;
  localparam logic [1:0]  CFG_UNUSED        = 2'd3;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  afs_pkg::afs_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  afs_pkg::afs_out_t out_data;
  logic     cfg_valid;
  logic     cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  // Predicted sequencer state and configuration.
  logic [15:0] cfg_step;
  logic [1:0]  cfg_mode;
  logic [8:0]  cfg_count;
  logic [31:0] acc;
  logic [7:0]  cur_frame;
  logic        playing_q;
  logic        finished_q;
  logic        reverse_q;
  logic [15:0] dur_tab [256];
  logic [3:0]  evcnt_tab [256];
  logic [7:0]  evid_tab [2048];
  bit          slot_written [2048];

  afs_pkg::afs_out_t sequence_words [$];

  int send_idle_pct;
  int recv_stall_pct;
  int hold_cycles;
  int words_sent;
  int words_checked;
  int events_seen;
  int destroys_seen;
  int mismatch_count;
  int cycle_count;

  animation_frame_sequencer_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d words outstanding.", cycle_count,
               sequence_words.size());
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("Mismatch at %0t on %s: got 0x%0h, expected 0x%0h.", $realtime, what, got,
             want);
    mismatch_count++;
  endtask

  // Predictor.
  function automatic void push_word(logic [1:0] kind, logic [7:0] value, logic last);
    afs_pkg::afs_out_t o;
    o.kind        = kind;
    o.event_value = value;
    o.frame_now   = cur_frame;
    o.is_playing  = playing_q;
    o.is_finished = finished_q;
    o.last        = last;
    sequence_words.push_back(o);
  endfunction

  function automatic void step_sequencer(afs_pkg::afs_in_t w);
    logic [32:0] sum;
    logic [15:0] dur;
    logic [7:0]  prev;
    int          span;
    int          nxt;
    int          n;
    span = (cfg_count > afs_pkg::MAX_FRAMES) ? int'(afs_pkg::MAX_FRAMES) : int'(cfg_count);
    case (w.func)
      afs_pkg::FUNC_TICK: begin
        if (playing_q && !finished_q && span != 0) begin
          sum = {1'b0, acc} + {1'b0, w.delta_ms};
          acc = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          dur = (dur_tab[cur_frame] != 16'd0) ? dur_tab[cur_frame] : cfg_step;
          if (acc >= {16'd0, dur}) begin
            acc  = acc - {16'd0, dur};
            prev = cur_frame;
            nxt  = int'(cur_frame);
            case (cfg_mode)
              afs_pkg::MODE_LOOP: begin
                nxt = (nxt + 1 >= span) ? 0 : nxt + 1;
              end
              afs_pkg::MODE_ONCE, afs_pkg::MODE_DESTROY: begin
                if (nxt + 1 >= span) begin
                  finished_q = 1'b1;
                  playing_q  = 1'b0;
                end else begin
                  nxt++;
                end
              end
              default: begin
                if (!reverse_q) begin
                  if (nxt + 1 >= span) begin
                    reverse_q = 1'b1;
                    if (nxt > 0) nxt--;
                  end else begin
                    nxt++;
                  end
                end else if (nxt == 0) begin
                  reverse_q = 1'b0;
                  if (span > 1) nxt = 1;
                end else begin
                  nxt--;
                end
              end
            endcase
            cur_frame = 8'(nxt);
            if (cfg_mode == afs_pkg::MODE_DESTROY && finished_q) begin
              push_word(afs_pkg::KIND_DESTROY, 8'd0, 1'b0);
            end else if (cur_frame != prev) begin
              n = (evcnt_tab[cur_frame] > afs_pkg::MAX_EVENTS) ? int'(afs_pkg::MAX_EVENTS)
                                                              : int'(evcnt_tab[cur_frame]);
              for (int e = 0; e < n; e++)
                push_word(afs_pkg::KIND_EVENT, evid_tab[{cur_frame, 3'(e)}], 1'b0);
            end
          end
        end
      end
      afs_pkg::FUNC_PLAY: begin
        cur_frame  = 8'd0;
        acc        = 32'd0;
        playing_q  = 1'b1;
        finished_q = 1'b0;
        reverse_q  = 1'b0;
      end
      afs_pkg::FUNC_STOP: begin
        playing_q = 1'b0;
      end
      afs_pkg::FUNC_WFRAME: begin
        dur_tab[w.frame_index]   = w.frame_dur;
        evcnt_tab[w.frame_index] = w.event_count;
      end
      afs_pkg::FUNC_WEVENT: begin
        evid_tab[{w.frame_index, w.event_slot}]     = w.event_code;
        slot_written[{w.frame_index, w.event_slot}] = 1'b1;
      end
      default: ;
    endcase
    push_word(afs_pkg::KIND_STATUS, 8'd0, 1'b1);
  endfunction

  // Result checking.
  always @(posedge clk) begin : word_check
    afs_pkg::afs_out_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready) begin
      words_checked++;
      if (out_data.kind == afs_pkg::KIND_EVENT) events_seen++;
      if (out_data.kind == afs_pkg::KIND_DESTROY) destroys_seen++;
      if (sequence_words.size() == 0) begin
        report_mismatch("unexpected word", 32'(out_data), 32'd0);
      end else begin
        want = sequence_words.pop_front();
        if (out_data.kind !== want.kind)
          report_mismatch("kind", 32'(out_data.kind), 32'(want.kind));
        if (out_data.event_value !== want.event_value)
          report_mismatch("event_value", 32'(out_data.event_value), 32'(want.event_value));
        if (out_data.frame_now !== want.frame_now)
          report_mismatch("frame_now", 32'(out_data.frame_now), 32'(want.frame_now));
        if (out_data.is_playing !== want.is_playing)
          report_mismatch("is_playing", 32'(out_data.is_playing), 32'(want.is_playing));
        if (out_data.is_finished !== want.is_finished)
          report_mismatch("is_finished", 32'(out_data.is_finished), 32'(want.is_finished));
        if (out_data.last !== want.last)
          report_mismatch("last", 32'(out_data.last), 32'(want.last));
      end
    end
  end

  // Receiver: random stalls and the long hold-off.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
    end
  end

  task automatic send_word(afs_pkg::afs_in_t w);
    @(negedge clk);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    step_sequencer(w);
    if (w.func <= afs_pkg::FUNC_WEVENT) words_sent++;
  endtask

  function automatic afs_pkg::afs_in_t noise_word(logic [2:0] func);
    afs_pkg::afs_in_t w;
    w.func        = func;
    w.delta_ms    = $urandom();
    w.frame_index = 8'($urandom());
    w.event_slot  = 3'($urandom());
    w.frame_dur   = 16'($urandom());
    w.event_count = 4'($urandom());
    w.event_code  = 8'($urandom());
    return w;
  endfunction

  task automatic send_tick(logic [31:0] delta);
    afs_pkg::afs_in_t w;
    w = noise_word(afs_pkg::FUNC_TICK);
    w.delta_ms = delta;
    send_word(w);
  endtask

  task automatic send_command(logic [2:0] func);
    send_word(noise_word(func));
  endtask

  task automatic write_event_slot(logic [7:0] fi, logic [2:0] slot, logic [7:0] code);
    afs_pkg::afs_in_t w;
    w = noise_word(afs_pkg::FUNC_WEVENT);
    w.frame_index = fi;
    w.event_slot  = slot;
    w.event_code  = code;
    send_word(w);
  endtask

  // Fills any slot that the new event count would expose before the entry.
  task automatic load_frame(logic [7:0] fi, logic [15:0] dur, logic [3:0] cnt);
    afs_pkg::afs_in_t w;
    int      need;
    need = (cnt > afs_pkg::MAX_EVENTS) ? int'(afs_pkg::MAX_EVENTS) : int'(cnt);
    for (int s = 0; s < need; s++)
      if (!slot_written[{fi, 3'(s)}]) write_event_slot(fi, 3'(s), 8'($urandom()));
    w = noise_word(afs_pkg::FUNC_WFRAME);
    w.frame_index = fi;
    w.frame_dur   = dur;
    w.event_count = cnt;
    send_word(w);
  endtask

  task automatic wait_quiet(int settle);
    while (sequence_words.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, logic [15:0] data);
    @(negedge clk);
    in_valid <= 1'b0;
    wait_quiet(8);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      afs_pkg::CFG_STEP:  cfg_step  = data;
      afs_pkg::CFG_MODE:  cfg_mode  = data[1:0];
      afs_pkg::CFG_COUNT: cfg_count = data[8:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_idle_words();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_tick(32'hFFFF_FFFF);
    send_command(afs_pkg::FUNC_STOP);
    for (int f = FUNC_UNUSED_FIRST; f <= FUNC_UNUSED_LAST; f++) send_command(3'(f));
    write_register(CFG_UNUSED, 16'hFFFF);
    send_command(afs_pkg::FUNC_PLAY);
    send_tick(32'd1000);
  endtask

  task automatic test_loop_events();
    write_register(afs_pkg::CFG_STEP, 16'd10);
    write_register(afs_pkg::CFG_COUNT, 16'd3);
    load_frame(8'd1, 16'd0, 4'd15);
    load_frame(8'd2, 16'hFFFF, 4'd1);
    load_frame(8'd255, 16'hFFFF, 4'd0);
    send_command(afs_pkg::FUNC_PLAY);
    send_tick(32'd9);
    send_tick(32'd1);
    send_tick(32'hFFFF_FFFF);
    send_tick(32'hFFFF_FFFF);
    send_command(afs_pkg::FUNC_STOP);
    send_tick(32'd50);
  endtask

  task automatic test_end_modes();
    write_register(afs_pkg::CFG_STEP, 16'd0);
    write_register(afs_pkg::CFG_MODE, 16'(afs_pkg::MODE_ONCE));
    write_register(afs_pkg::CFG_COUNT, 16'd2);
    send_command(afs_pkg::FUNC_PLAY);
    repeat (3) send_tick(32'd0);
    send_command(afs_pkg::FUNC_STOP);
    write_register(afs_pkg::CFG_MODE, 16'(afs_pkg::MODE_DESTROY));
    send_command(afs_pkg::FUNC_PLAY);
    repeat (3) send_tick(32'd0);
    write_register(afs_pkg::CFG_MODE, 16'(afs_pkg::MODE_PINGPONG));
    write_register(afs_pkg::CFG_COUNT, 16'd1);
    send_command(afs_pkg::FUNC_PLAY);
    repeat (2) send_tick(32'd0);
    write_register(afs_pkg::CFG_COUNT, 16'd3);
    send_command(afs_pkg::FUNC_PLAY);
    repeat (5) send_tick(32'd65535);
  endtask

  task automatic test_frame_limits();
    write_register(afs_pkg::CFG_STEP, 16'd1);
    write_register(afs_pkg::CFG_MODE, 16'(afs_pkg::MODE_LOOP));
    write_register(afs_pkg::CFG_COUNT, 16'd511);
    send_command(afs_pkg::FUNC_PLAY);
    send_tick(32'd1);
    write_register(afs_pkg::CFG_COUNT, 16'd3);
    send_command(afs_pkg::FUNC_PLAY);
    repeat (2) send_tick(32'd1);
    write_register(afs_pkg::CFG_COUNT, 16'd2);
    send_tick(32'd65535);
    write_register(afs_pkg::CFG_MODE, 16'(afs_pkg::MODE_ONCE));
    write_register(afs_pkg::CFG_COUNT, 16'd3);
    send_command(afs_pkg::FUNC_PLAY);
    repeat (2) send_tick(32'd1);
    write_register(afs_pkg::CFG_COUNT, 16'd2);
    send_tick(32'd65535);
    write_register(afs_pkg::CFG_STEP, 16'hFFFF);
    write_register(afs_pkg::CFG_MODE, 16'(afs_pkg::MODE_LOOP));
    write_register(afs_pkg::CFG_COUNT, 16'd256);
    send_command(afs_pkg::FUNC_PLAY);
    send_tick(32'd65534);
    send_tick(32'd1);
  endtask

  task automatic test_backpressure();
    write_register(afs_pkg::CFG_STEP, 16'd0);
    write_register(afs_pkg::CFG_MODE, 16'(afs_pkg::MODE_LOOP));
    write_register(afs_pkg::CFG_COUNT, 16'd2);
    load_frame(8'd0, 16'd0, 4'd8);
    load_frame(8'd1, 16'd0, 4'd8);
    send_command(afs_pkg::FUNC_PLAY);
    hold_cycles = 300;
    repeat (24) send_tick(32'd0);
  endtask

  task automatic test_random_traffic(int idle_pct, int stall_pct, int words);
    int         first;
    int         pick;
    int         span;
    logic [8:0] cnt;
    logic [7:0] fi;
    logic [15:0] dur;
    logic [31:0] delta;
    write_register(afs_pkg::CFG_STEP, 16'($urandom_range(12, 0)));
    write_register(afs_pkg::CFG_MODE, 16'($urandom_range(3, 0)));
    case ($urandom_range(9, 0))
      0: cnt = 9'd1;
      1: cnt = 9'd256;
      default: cnt = 9'($urandom_range(8, 2));
    endcase
    write_register(afs_pkg::CFG_COUNT, 16'(cnt));
    span = (cnt > 8) ? 8 : int'(cnt);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    first = words_sent;
    send_command(afs_pkg::FUNC_PLAY);
    while (words_sent - first < words) begin
      pick = $urandom_range(99, 0);
      if (pick < 55) begin
        case ($urandom_range(9, 0))
          0: delta = $urandom();
          1: delta = 32'd0;
          default: delta = 32'($urandom_range(20, 0));
        endcase
        send_tick(delta);
      end else if (pick < 67) begin
        fi  = ($urandom_range(99, 0) < 80) ? 8'($urandom_range(span - 1, 0))
                                           : 8'($urandom_range(255, 0));
        dur = ($urandom_range(99, 0) < 85) ? 16'($urandom_range(15, 0))
                                           : 16'($urandom());
        load_frame(fi, dur, 4'($urandom_range(15, 0)));
      end else if (pick < 75) begin
        write_event_slot(8'($urandom()), 3'($urandom()), 8'($urandom()));
      end else if (pick < 85) begin
        send_command(afs_pkg::FUNC_PLAY);
      end else if (pick < 92) begin
        send_command(afs_pkg::FUNC_STOP);
      end else if (pick < 96) begin
        send_command(3'($urandom_range(FUNC_UNUSED_LAST, FUNC_UNUSED_FIRST)));
      end else begin
        send_tick($urandom());
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 0;
    words_sent     = 0;
    words_checked  = 0;
    events_seen    = 0;
    destroys_seen  = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    cfg_step       = afs_pkg::RESET_STEP_MS;
    cfg_mode       = afs_pkg::MODE_LOOP;
    cfg_count      = 9'd0;
    acc            = 32'd0;
    cur_frame      = 8'd0;
    playing_q      = 1'b0;
    finished_q     = 1'b0;
    reverse_q      = 1'b0;
    for (int i = 0; i < 256; i++) begin
      dur_tab[i]   = 16'd0;
      evcnt_tab[i] = 4'd0;
    end
    for (int i = 0; i < 2048; i++) begin
      evid_tab[i]     = 8'd0;
      slot_written[i] = 1'b0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_idle_words();
    test_loop_events();
    test_end_modes();
    test_frame_limits();
    test_backpressure();
    test_random_traffic(0, 0, 45);
    test_random_traffic(78, 0, 45);
    test_random_traffic(0, 78, 45);
    test_random_traffic(24, 24, 45);

    @(negedge clk);
    in_valid <= 1'b0;
    wait_quiet(30);
    $display("Run sent %0d input words and checked %0d result words, %0d frame events",
             words_sent, words_checked, events_seen);
    $display("and %0d destroy events, over all play modes and frame counts 0 to 511.",
             destroys_seen);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches found.", mismatch_count);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/afs_pkg.sv
rtl/core/afs_ctrl.sv
rtl/core/afs_datapath.sv
rtl/core/animation_frame_sequencer_top.sv
tb/animation_frame_sequencer_top_tb.sv
